// ===== hdl/bbd_pkg.sv =====
// ----------------------------------------------------------------------------
// bbd_pkg
// Shared types and constants of the bilinear Bayer demosaic block.
// ----------------------------------------------------------------------------
package bbd_pkg;

   localparam int ROW_BITS       = 16;
   localparam int COL_BITS       = 12;
   localparam int WIDTH_REG_BITS = 13;
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET  = 13'd640;
   localparam logic [ROW_BITS-1:0]       HEIGHT_RESET = 16'd480;

   // colour site of the window centre
   typedef enum logic [1:0] {
      SITE_GR = 2'd0,   // green on a red row
      SITE_R  = 2'd1,
      SITE_B  = 2'd2,
      SITE_GB = 2'd3    // green on a blue row
   } site_type;

   // per-pixel control from the position stage
   typedef struct packed {
      logic emit;       // window centre is interior
      logic last;       // last interior pixel of the frame
   } pos_flags_type;

endpackage

// ===== hdl/bbd_ram.sv =====
// ----------------------------------------------------------------------------
// bbd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/bbd_pos.sv =====
// ----------------------------------------------------------------------------
// bbd_pos
// Raster position tracking: clamps the frame size, places each incoming
// sample and flags interior and last-pixel windows.
// ----------------------------------------------------------------------------
module bbd_pos
   import bbd_pkg::*;
#(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          frame_start,
   input  logic [WIDTH_REG_BITS-1:0]     width_reg,
   input  logic [ROW_BITS-1:0]           height_reg,
   output logic [$clog2(MAX_WIDTH)-1:0]  col,
   output logic [ROW_BITS-1:0]           row,
   output pos_flags_type                 flags
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int WW = (AW + 1 > WIDTH_REG_BITS) ? AW + 1 : WIDTH_REG_BITS;

   logic [AW-1:0]       col_ff, col_in;
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [WW-1:0]       w_eff;
   logic [ROW_BITS-1:0] h_eff;
   logic [AW-1:0]       col_start;
   logic [ROW_BITS:0]   row_start, row_adv, row_nx;
   logic [AW-1:0]       cc;
   logic [ROW_BITS-1:0] rr;
   logic [WW-1:0]       col_nx;

   always_comb begin
      if (WW'(width_reg) < WW'(3)) begin
         w_eff = WW'(3);
      end else if (WW'(width_reg) > WW'(MAX_WIDTH)) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(width_reg);
      end
      h_eff = (height_reg < ROW_BITS'(3)) ? ROW_BITS'(3) : height_reg;
   end

   always_comb begin
      col_start = frame_start ? '0 : col_ff;
      row_start = frame_start ? '0 : {1'b0, row_ff};
      // position left past the frame by a register change
      if (WW'(col_start) >= w_eff) begin
         cc      = '0;
         row_adv = row_start + 1'b1;
      end else begin
         cc      = col_start;
         row_adv = row_start;
      end
      rr = (row_adv >= {1'b0, h_eff}) ? '0 : row_adv[ROW_BITS-1:0];

      col_nx = WW'(cc) + 1'b1;
      row_nx = {1'b0, rr} + 1'b1;
      if (col_nx >= w_eff) begin
         col_in = '0;
         row_in = (row_nx >= {1'b0, h_eff}) ? '0 : row_nx[ROW_BITS-1:0];
      end else begin
         col_in = col_nx[AW-1:0];
         row_in = rr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign col        = cc;
   assign row        = rr;
   assign flags.emit = (rr >= ROW_BITS'(2)) && (cc >= AW'(2));
   assign flags.last = (rr == h_eff - 1'b1) && (WW'(cc) == w_eff - 1'b1);

endmodule

// ===== hdl/bbd_interp.sv =====
// ----------------------------------------------------------------------------
// bbd_interp
// Bilinear interpolation of one 3x3 window: own sample plus truncated
// averages of two or four neighbours, chosen by colour site.
// ----------------------------------------------------------------------------
module bbd_interp
   import bbd_pkg::*;
#(
   parameter int SAMPLE_BITS = 8
) (
   // column-major taps: m00 m10 m20 m01 m11 m21 m02 m12 m22 (row, col)
   input  logic [8:0][SAMPLE_BITS-1:0] taps,
   input  site_type                    site,
   output logic [SAMPLE_BITS-1:0]      red,
   output logic [SAMPLE_BITS-1:0]      green,
   output logic [SAMPLE_BITS-1:0]      blue
);

   localparam int S = SAMPLE_BITS;

   logic [S:0]   sum_hor, sum_ver;
   logic [S+1:0] sum_crs, sum_dia;
   logic [S-1:0] ctr, hor, ver, crs, dia;

   always_comb begin
      sum_hor = {1'b0, taps[1]} + {1'b0, taps[7]};
      sum_ver = {1'b0, taps[3]} + {1'b0, taps[5]};
      sum_crs = {1'b0, sum_hor} + {1'b0, sum_ver};
      sum_dia = (S+2)'(taps[0]) + (S+2)'(taps[6]) + (S+2)'(taps[2]) + (S+2)'(taps[8]);
      ctr     = taps[4];
      hor     = sum_hor[S:1];
      ver     = sum_ver[S:1];
      crs     = sum_crs[S+1:2];
      dia     = sum_dia[S+1:2];
   end

   always_comb begin
      unique case (site)
         SITE_GR: begin
            green = ctr; red = hor; blue = ver;
         end
         SITE_R: begin
            red = ctr; green = crs; blue = dia;
         end
         SITE_B: begin
            blue = ctr; green = crs; red = dia;
         end
         SITE_GB: begin
            green = ctr; red = ver; blue = hor;
         end
         default: begin
            green = ctr; red = ver; blue = hor;
         end
      endcase
   end

endmodule

// ===== hdl/bayer_bilinear_demosaic.sv =====
// ----------------------------------------------------------------------------
// bayer_bilinear_demosaic
// The transfer of the sample that completes a window loads the first stage;
// the result register loads from that stage when it advances. Throughput:
// one sample per cycle, set by the single line-store RAM read and write per
// sample; the input stalls only while a waiting result blocks the next
// interior window. Reset (synchronous) clears the position, window and
// handshake state and loads 640 x 480; the line store is not cleared and
// needs no clearing pass.
// ----------------------------------------------------------------------------
module bayer_bilinear_demosaic
   import bbd_pkg::*;
#(
   parameter int MAX_WIDTH   = 4096,
   parameter int SAMPLE_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // raw sample input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_raw_value,
   input  logic                      req_frame_start,
   // RGB result output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [ROW_BITS-1:0]       rsp_out_row,
   output logic [COL_BITS-1:0]       rsp_out_col,
   output logic [SAMPLE_BITS-1:0]    rsp_red,
   output logic [SAMPLE_BITS-1:0]    rsp_green,
   output logic [SAMPLE_BITS-1:0]    rsp_blue,
   output logic                      rsp_frame_last,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int AW = $clog2(MAX_WIDTH);
   localparam int S  = SAMPLE_BITS;

   logic [WIDTH_REG_BITS-1:0] width_ff;
   logic [ROW_BITS-1:0]       height_ff;

   logic                accept, s1_go;
   logic [AW-1:0]       pos_col;
   logic [ROW_BITS-1:0] pos_row;
   pos_flags_type       pos_flags;

   logic                s1_valid_ff, s1_valid_in;
   logic [AW-1:0]       s1_col_ff;
   logic [ROW_BITS-1:0] s1_row_ff;
   logic [S-1:0]        s1_raw_ff;
   pos_flags_type       s1_flags_ff;
   logic                fwd_ff;
   logic [2*S-1:0]      fwd_data_ff;

   logic [2*S-1:0]      rd_data, line, wr_data;
   logic [S-1:0]        up, mid;
   logic [5:0][S-1:0]   win_ff;
   logic [8:0][S-1:0]   taps;
   site_type            site;
   logic [S-1:0]        red, green, blue;

   logic                rsp_valid_ff, rsp_valid_in;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_data[WIDTH_REG_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_data[ROW_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign s1_go     = s1_valid_ff && (!s1_flags_ff.emit || !rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   bbd_pos #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_pos (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .frame_start (req_frame_start),
      .width_reg   (width_ff),
      .height_reg  (height_ff),
      .col         (pos_col),
      .row         (pos_row),
      .flags       (pos_flags)
   );

   // line store: {upper, middle} per column
   assign line    = fwd_ff ? fwd_data_ff : rd_data;
   assign up      = line[2*S-1:S];
   assign mid     = line[S-1:0];
   assign wr_data = {mid, s1_raw_ff};

   bbd_ram #(
      .WIDTH (2 * S),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (pos_col),
      .rd_data (rd_data)
   );

   assign s1_valid_in = accept ? 1'b1 : (s1_go ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (accept) begin
            // same column written back in this cycle: bypass the RAM read
            fwd_ff <= s1_go && (pos_col == s1_col_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= pos_col;
         s1_row_ff   <= pos_row;
         s1_raw_ff   <= req_raw_value;
         s1_flags_ff <= pos_flags;
         fwd_data_ff <= wr_data;
      end
   end

   // 3x3 window: two older columns held here, newest column from line store and new sample
   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_go) begin
         win_ff <= {s1_raw_ff, mid, up, win_ff[5], win_ff[4], win_ff[3]};
      end
   end

   assign taps = {s1_raw_ff, mid, up, win_ff};

   always_comb begin
      unique case ({~s1_row_ff[0], ~s1_col_ff[0]})
         2'b00:   site = SITE_GR;
         2'b01:   site = SITE_R;
         2'b10:   site = SITE_B;
         default: site = SITE_GB;
      endcase
   end

   bbd_interp #(
      .SAMPLE_BITS (S)
   ) u_interp (
      .taps  (taps),
      .site  (site),
      .red   (red),
      .green (green),
      .blue  (blue)
   );

   // output register
   always_comb begin
      priority if (s1_go && s1_flags_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_flags_ff.emit) begin
         rsp_out_row    <= s1_row_ff - 1'b1;
         rsp_out_col    <= COL_BITS'(s1_col_ff - 1'b1);
         rsp_red        <= red;
         rsp_green      <= green;
         rsp_blue       <= blue;
         rsp_frame_last <= s1_flags_ff.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sim/bbd_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// bbd_pixel_checker
// Watches the sample, result and register channels of the Bayer demosaic
// block. Every accepted sample is run through a local line-store and window
// model that yields the expected RGB pixel, if any. Each result transfer is
// compared field by field against the oldest expected pixel. Mismatches and
// unexpected results are counted and passed up as fail_count.
// ----------------------------------------------------------------------------
module bbd_pixel_checker
   import bbd_pkg::*;
#(
   parameter int MAX_WIDTH   = 4096,
   parameter int SAMPLE_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_raw_value,
   input  logic                      req_frame_start,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [ROW_BITS-1:0]       rsp_out_row,
   input  logic [COL_BITS-1:0]       rsp_out_col,
   input  logic [SAMPLE_BITS-1:0]    rsp_red,
   input  logic [SAMPLE_BITS-1:0]    rsp_green,
   input  logic [SAMPLE_BITS-1:0]    rsp_blue,
   input  logic                      rsp_frame_last,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   output int                        fail_count,
   output int                        pending_count
);

   localparam int REPORT_LIMIT = 200;

   typedef struct packed {
      logic [ROW_BITS-1:0]    row;
      logic [COL_BITS-1:0]    col;
      logic [SAMPLE_BITS-1:0] red;
      logic [SAMPLE_BITS-1:0] green;
      logic [SAMPLE_BITS-1:0] blue;
      logic                   last;
   } rgb_pixel_type;

   rgb_pixel_type             pixel_queue [$];
   logic [SAMPLE_BITS-1:0]    upper_row  [MAX_WIDTH];
   logic [SAMPLE_BITS-1:0]    middle_row [MAX_WIDTH];
   int                        window [6];   // [0..2] column x-1, [3..5] column x
   logic [WIDTH_REG_BITS-1:0] width_reg;
   logic [ROW_BITS-1:0]       height_reg;
   int                        col_pos;
   int                        row_pos;
   int                        errors = 0;
   int                        reported = 0;

   assign fail_count = errors;

   task automatic demosaic_sample(input logic [SAMPLE_BITS-1:0] raw, input logic start);
      int w, h, c, r, x, y;
      int up, mid, ctr, hor, ver, crs, dia;
      rgb_pixel_type px;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      h = (height_reg < 3) ? 3 : height_reg;
      if (start) begin
         col_pos = 0;
         row_pos = 0;
      end
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;
      up = upper_row[c];
      mid = middle_row[c];
      if (r >= 2 && c >= 2) begin
         y = r - 1;
         x = c - 1;
         ctr = window[4];
         hor = (window[1] + mid) / 2;
         ver = (window[3] + window[5]) / 2;
         crs = (window[1] + mid + window[3] + window[5]) / 4;
         dia = (window[0] + up + window[2] + int'(raw)) / 4;
         px.row = ROW_BITS'(y);
         px.col = COL_BITS'(x);
         unique case (site_type'({y[0], x[0]}))
            SITE_GR: begin
               px.green = SAMPLE_BITS'(ctr);
               px.red   = SAMPLE_BITS'(hor);
               px.blue  = SAMPLE_BITS'(ver);
            end
            SITE_R: begin
               px.red   = SAMPLE_BITS'(ctr);
               px.green = SAMPLE_BITS'(crs);
               px.blue  = SAMPLE_BITS'(dia);
            end
            SITE_B: begin
               px.blue  = SAMPLE_BITS'(ctr);
               px.green = SAMPLE_BITS'(crs);
               px.red   = SAMPLE_BITS'(dia);
            end
            SITE_GB: begin
               px.green = SAMPLE_BITS'(ctr);
               px.red   = SAMPLE_BITS'(ver);
               px.blue  = SAMPLE_BITS'(hor);
            end
         endcase
         px.last = (r == h - 1) && (c == w - 1);
         pixel_queue = {pixel_queue, px};
      end
      window[0] = window[3];
      window[1] = window[4];
      window[2] = window[5];
      window[3] = up;
      window[4] = mid;
      window[5] = raw;
      upper_row[c] = SAMPLE_BITS'(mid);
      middle_row[c] = raw;
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos >= h) row_pos = 0;
      end
   endtask

   function automatic void compare_field(string name, rgb_pixel_type want,
                                         logic [31:0] want_v, logic [31:0] got_v);
      if (got_v !== want_v) begin
         errors++;
         if (reported < REPORT_LIMIT) begin
            reported++;
            $display("%0t: pixel row %0d col %0d %s expected %0d got %0d",
                     $time, want.row, want.col, name, want_v, got_v);
         end
      end
   endfunction

   always @(posedge clock) begin : observe
      rgb_pixel_type want;
      if (reset) begin
         pixel_queue.delete();
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i] = '0;
            middle_row[i] = '0;
         end
         for (int i = 0; i < 6; i++) window[i] = 0;
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         col_pos = 0;
         row_pos = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg = csr_data[WIDTH_REG_BITS-1:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_data[ROW_BITS-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) demosaic_sample(req_raw_value, req_frame_start);
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               errors++;
               if (reported < REPORT_LIMIT) begin
                  reported++;
                  $display("%0t: result row %0d col %0d expected none got rgb %0d %0d %0d",
                           $time, rsp_out_row, rsp_out_col, rsp_red, rsp_green, rsp_blue);
               end
            end else begin
               want = pixel_queue.pop_front();
               compare_field("out_row", want, want.row, rsp_out_row);
               compare_field("out_col", want, want.col, rsp_out_col);
               compare_field("red", want, want.red, rsp_red);
               compare_field("green", want, want.green, rsp_green);
               compare_field("blue", want, want.blue, rsp_blue);
               compare_field("frame_last", want, want.last, rsp_frame_last);
            end
         end
      end
      pending_count <= pixel_queue.size();
   end

endmodule

// ===== sim/tb_bayer_bilinear_demosaic.sv =====
// ----------------------------------------------------------------------------
// tb_bayer_bilinear_demosaic
// Drives raw mosaic samples and register writes into the demosaic block with
// random idle gaps and result back-pressure. A short run at the reset
// geometry, short directed frames covering all four colour sites and the
// lower size clamps, then random frames, partial frames and mid-frame geometry
// changes. The pixel checker predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module tb_bayer_bilinear_demosaic;
   import bbd_pkg::*;

   localparam int MAX_WIDTH       = 4096;
   localparam int SAMPLE_BITS     = 8;
   localparam int LIMIT           = 500_000;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int RESET_ITEMS     = 40;
   localparam int RANDOM_ITEMS    = 1000;
   localparam int FRAME_CAP       = 300;
   localparam int MAX_IDLE        = 18;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [SAMPLE_BITS-1:0]    req_raw_value;
   logic                      req_frame_start;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [ROW_BITS-1:0]       rsp_out_row;
   logic [COL_BITS-1:0]       rsp_out_col;
   logic [SAMPLE_BITS-1:0]    rsp_red;
   logic [SAMPLE_BITS-1:0]    rsp_green;
   logic [SAMPLE_BITS-1:0]    rsp_blue;
   logic                      rsp_frame_last;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;
   int                        fail_count;
   int                        pending_count;

   int   hold_off_req;
   int   req_burst;
   int   rsp_burst;
   int   cur_width;
   int   cur_height;

   bayer_bilinear_demosaic #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) dut (.*);

   bbd_pixel_checker #(
      .MAX_WIDTH   (MAX_WIDTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) pixel_check (.*);

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin : watchdog
      int cycles;
      for (cycles = 0; cycles < LIMIT; cycles++) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   // mostly random gaps, with occasional runs of back-to-back transfers
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, MAX_IDLE);
   endfunction

   task automatic push_sample(input logic [SAMPLE_BITS-1:0] value, input logic start);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_value <= value;
      req_frame_start <= start;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_idle;
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_registers(input bit set_w, input int width_value,
                                    input bit set_h, input int height_value);
      logic [CSR_DATA_BITS-1:0] word;
      if (set_w) begin
         word = CSR_DATA_BITS'($urandom_range(0, 65535));
         word[WIDTH_REG_BITS-1:0] = WIDTH_REG_BITS'(width_value);
         csr_valid <= 1'b1;
         csr_index <= CSR_IMAGE_WIDTH;
         csr_data <= word;
         cur_width = width_value % (1 << WIDTH_REG_BITS);
         do @(posedge clock); while (!csr_ready);
      end
      if (set_h) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IMAGE_HEIGHT;
         csr_data <= CSR_DATA_BITS'(height_value);
         cur_height = height_value;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   // result side: random stall after each transfer, long hold-off on request
   initial begin : result_sink
      int gap, hold_done;
      rsp_stall <= 1'b0;
      hold_done = 0;
      rsp_burst = 0;
      forever begin
         @(posedge clock);
         if (hold_off_req != hold_done) begin
            hold_done = hold_off_req;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (rsp_valid && !rsp_stall) begin
            gap = draw_gap(rsp_burst);
            if (gap > 0) begin
               rsp_stall <= 1'b1;
               repeat (gap) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      logic [SAMPLE_BITS-1:0] tiny_frame [9];
      logic [SAMPLE_BITS-1:0] site_frame [16];
      int  sent, n, pick, w, h, ew, eh, old_ew;
      bit  held, set_w, set_h;
      tiny_frame = '{8'd255, 8'd0, 8'd255, 8'd254, 8'd255, 8'd1, 8'd255, 8'd0, 8'd255};
      site_frame = '{8'd255, 8'd254, 8'd0, 8'd1, 8'd253, 8'd255, 8'd255, 8'd0,
                     8'd0, 8'd255, 8'd1, 8'd254, 8'd255, 8'd0, 8'd255, 8'd255};
      hold_off_req = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_raw_value <= '0;
      req_frame_start <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data <= '0;
      req_burst = 0;
      cur_width = int'(WIDTH_RESET);
      cur_height = int'(HEIGHT_RESET);
      held = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset geometry: start of the first row
      push_sample(SAMPLE_BITS'($urandom_range(0, 255)), 1'b1);
      for (int i = 1; i < RESET_ITEMS; i++)
         push_sample(SAMPLE_BITS'($urandom_range(0, 255)), 1'b0);
      wait_idle();

      // width and height below range clamp to 3x3; one extra sample wraps
      program_registers(1'b1, 2, 1'b1, 0);
      for (int i = 0; i < 9; i++) push_sample(tiny_frame[i], i == 0);
      push_sample(8'h80, 1'b0);
      wait_idle();

      // 4x4 frame: one pixel of each colour site, started in the middle of the previous frame
      program_registers(1'b1, 4, 1'b1, 4);
      for (int i = 0; i < 16; i++) push_sample(site_frame[i], i == 0);
      wait_idle();

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         set_w = 1'($urandom_range(0, 1));
         set_h = ($urandom_range(0, 2) == 0);
         pick = $urandom_range(0, 15);
         if (pick == 0) w = $urandom_range(0, 2);
         else if (pick == 1) w = $urandom_range(0, 1) ? MAX_WIDTH
                                  : $urandom_range(MAX_WIDTH + 1, 8191);
         else w = $urandom_range(3, 10);
         pick = $urandom_range(0, 15);
         if (pick == 0) h = $urandom_range(0, 2);
         else if (pick == 1) h = 65535;
         else h = $urandom_range(3, 8);
         old_ew = (cur_width < 3) ? 3 : (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
         program_registers(set_w, w, set_h, h);
         ew = (cur_width < 3) ? 3 : (cur_width > MAX_WIDTH) ? MAX_WIDTH : cur_width;
         eh = (cur_height < 3) ? 3 : cur_height;
         if ($urandom_range(0, 3) != 0) begin
            n = (ew * eh > FRAME_CAP) ? FRAME_CAP : ew * eh;
            if (n >= 40 && (!held || $urandom_range(0, 19) == 0)) begin
               hold_off_req <= hold_off_req + 1;
               held = 1'b1;
            end
            for (int i = 0; i < n; i++)
               push_sample(SAMPLE_BITS'($urandom_range(0, 255)), i == 0);
         end else begin
            // a wider line restarts the frame so no unwritten column is read
            n = $urandom_range(1, 40);
            for (int i = 0; i < n; i++)
               push_sample(SAMPLE_BITS'($urandom_range(0, 255)),
                           (i == 0 && ew > old_ew) || $urandom_range(0, 7) == 0);
         end
         sent += n;
      end

      wait_idle();
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
